// ===== src/trsr_pkg.sv =====
// ----------------------------------------------------------------------------
// trsr_pkg: shared types and constants for the trim-and-respond setpoint reset
// Holds the action codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package trsr_pkg;

  localparam int unsigned SP_W      = 16;
  localparam int unsigned REQ_W     = 8;
  localparam int unsigned SEC_W     = 16;
  localparam int unsigned TIMER_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  typedef logic signed [SP_W-1:0] setpoint_t;

  typedef enum logic [2:0] {
    ACT_RESET   = 3'd0,
    ACT_STARTUP = 3'd1,
    ACT_WAIT    = 3'd2,
    ACT_TRIM    = 3'd3,
    ACT_RESPOND = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_SETPOINT = 3'd0,
    REG_SETPOINT_FLOOR   = 3'd1,
    REG_SETPOINT_CEILING = 3'd2,
    REG_CADENCE_SECONDS  = 3'd3,
    REG_IGNORED_REQUESTS = 3'd4,
    REG_TRIM_STEP        = 3'd5,
    REG_RESPOND_GAIN     = 3'd6,
    REG_RESPOND_LIMIT    = 3'd7
  } cfg_reg_t;

  localparam setpoint_t         RST_INITIAL_SETPOINT = 16'sd1000;
  localparam setpoint_t         RST_SETPOINT_FLOOR   = 16'sd150;
  localparam setpoint_t         RST_SETPOINT_CEILING = 16'sd1500;
  localparam logic [SEC_W-1:0]  RST_CADENCE_SECONDS  = 16'd120;
  localparam logic [REQ_W-1:0]  RST_IGNORED_REQUESTS = 8'd2;
  localparam setpoint_t         RST_TRIM_STEP        = -16'sd50;
  localparam setpoint_t         RST_RESPOND_GAIN     = 16'sd60;
  localparam setpoint_t         RST_RESPOND_LIMIT    = 16'sd150;

endpackage

// ===== src/trsr_if.sv =====
// ----------------------------------------------------------------------------
// trsr_if: valid/ready channels for the setpoint reset block
// Tick words in, setpoint result words out.
// ----------------------------------------------------------------------------
interface trsr_in_if;
  logic                            valid;
  logic                            ready;
  logic                            fan_running;
  logic [trsr_pkg::REQ_W-1:0]      request_count;
  logic [trsr_pkg::SEC_W-1:0]      elapsed_seconds;

  modport source (output valid, fan_running, request_count, elapsed_seconds,
                  input ready);
  modport sink   (input valid, fan_running, request_count, elapsed_seconds,
                  output ready);
endinterface

interface trsr_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [trsr_pkg::SP_W-1:0] setpoint_out;
  logic [2:0]                      action_taken;

  modport source (output valid, setpoint_out, action_taken, input ready);
  modport sink   (input valid, setpoint_out, action_taken, output ready);
endinterface

// ===== src/trim_respond_setpoint_reset_top.sv =====
// The result word of an accepted tick word is loaded into the result register as the word is accepted.
// Throughput: one tick word per cycle while the result is read out; the single result register sets this rate.
// The input is taken whenever the result register is empty or is being read out.
// Reset (rst_n low, synchronous): registers return to their defaults, the
// setpoint and both timers clear, the fan history reads off, no result is held.
// ----------------------------------------------------------------------------
// trim_respond_setpoint_reset_top: trim-and-respond setpoint reset
// Tracks fan edges, a startup timer and a cadence timer, and per control tick
// resets, holds or waits, or trims or responds the setpoint, clamped to the configured bounds.
// ----------------------------------------------------------------------------
module trim_respond_setpoint_reset_top #(
  parameter int unsigned STARTUP_DELAY_SECONDS = 600
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [trsr_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [trsr_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  trsr_in_if.sink                            in_ch,
  trsr_out_if.source                         out_ch
);

  localparam int unsigned TW = trsr_pkg::TIMER_W;
  localparam logic [TW-1:0] STARTUP_LIMIT = TW'(STARTUP_DELAY_SECONDS);

  // Configuration registers
  trsr_pkg::setpoint_t              initial_setpoint_r;
  trsr_pkg::setpoint_t              setpoint_floor_r;
  trsr_pkg::setpoint_t              setpoint_ceiling_r;
  logic [trsr_pkg::SEC_W-1:0]       cadence_seconds_r;
  logic [trsr_pkg::REQ_W-1:0]       ignored_requests_r;
  trsr_pkg::setpoint_t              trim_step_r;
  trsr_pkg::setpoint_t              respond_gain_r;
  trsr_pkg::setpoint_t              respond_limit_r;

  // Loop state
  trsr_pkg::setpoint_t              setpoint_r, setpoint_nxt;
  logic [TW-1:0]                    startup_timer_r, startup_timer_nxt;
  logic [TW-1:0]                    cadence_timer_r, cadence_timer_nxt;
  logic                             fan_was_on_r, fan_was_on_nxt;

  // Result register
  logic                             out_valid_r;
  trsr_pkg::setpoint_t              out_setpoint_r;
  trsr_pkg::action_t                out_action_r, action_nxt;

  logic                             accept;

  // Datapath intermediates
  logic [TW:0]                      startup_sum, cadence_sum;
  logic [TW-1:0]                    startup_sat, cadence_sat;
  logic                             do_trim;
  logic [trsr_pkg::REQ_W-1:0]       excess;
  logic signed [24:0]               amount;
  logic signed [24:0]               amount_lim;
  logic signed [25:0]               step;
  logic signed [25:0]               candidate;
  trsr_pkg::setpoint_t              clamped;

  // Take a new word whenever the result slot frees up this cycle.
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.setpoint_out = out_setpoint_r;
  assign out_ch.action_taken = out_action_r;

  // Saturating timer advance by the elapsed seconds of this tick.
  assign startup_sum = {1'b0, startup_timer_r} + (TW+1)'(in_ch.elapsed_seconds);
  assign cadence_sum = {1'b0, cadence_timer_r} + (TW+1)'(in_ch.elapsed_seconds);
  assign startup_sat = startup_sum[TW] ? '1 : startup_sum[TW-1:0];
  assign cadence_sat = cadence_sum[TW] ? '1 : cadence_sum[TW-1:0];

  // Trim when requests are at or below the ignore level, else respond with
  // the gain times the excess, limited in the direction of the gain sign.
  assign do_trim = in_ch.request_count <= ignored_requests_r;
  assign excess  = in_ch.request_count - ignored_requests_r;
  assign amount  = 25'(respond_gain_r) * 25'($signed({1'b0, excess}));

  always_comb begin
    if (respond_gain_r > 16'sd0) begin
      amount_lim = (amount > 25'(respond_limit_r)) ? 25'(respond_limit_r) : amount;
    end else begin
      amount_lim = (amount < 25'(respond_limit_r)) ? 25'(respond_limit_r) : amount;
    end
  end

  assign step      = do_trim ? 26'(trim_step_r) : 26'(amount_lim);
  assign candidate = 26'(setpoint_r) + step;

  // The floor is checked first: when the two cross, a candidate below the floor gets the floor, any other the ceiling.
  always_comb begin
    if (candidate < 26'(setpoint_floor_r)) begin
      clamped = setpoint_floor_r;
    end else if (candidate > 26'(setpoint_ceiling_r)) begin
      clamped = setpoint_ceiling_r;
    end else begin
      clamped = candidate[trsr_pkg::SP_W-1:0];
    end
  end

  // Tick decision: fan-off or fan-on-edge reset, startup hold, cadence wait, or act.
  always_comb begin
    setpoint_nxt      = setpoint_r;
    startup_timer_nxt = startup_timer_r;
    cadence_timer_nxt = cadence_timer_r;
    fan_was_on_nxt    = fan_was_on_r;
    action_nxt        = trsr_pkg::ACT_RESET;
    if (!in_ch.fan_running || !fan_was_on_r) begin
      fan_was_on_nxt    = in_ch.fan_running;
      setpoint_nxt      = initial_setpoint_r;
      startup_timer_nxt = '0;
      cadence_timer_nxt = '0;
      action_nxt        = trsr_pkg::ACT_RESET;
    end else begin
      startup_timer_nxt = startup_sat;
      if (startup_sat < STARTUP_LIMIT) begin
        setpoint_nxt = initial_setpoint_r;
        action_nxt   = trsr_pkg::ACT_STARTUP;
      end else begin
        cadence_timer_nxt = cadence_sat;
        if (cadence_sat < TW'(cadence_seconds_r)) begin
          action_nxt = trsr_pkg::ACT_WAIT;
        end else begin
          cadence_timer_nxt = '0;
          setpoint_nxt      = clamped;
          action_nxt        = do_trim ? trsr_pkg::ACT_TRIM : trsr_pkg::ACT_RESPOND;
        end
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_setpoint_r <= trsr_pkg::RST_INITIAL_SETPOINT;
      setpoint_floor_r   <= trsr_pkg::RST_SETPOINT_FLOOR;
      setpoint_ceiling_r <= trsr_pkg::RST_SETPOINT_CEILING;
      cadence_seconds_r  <= trsr_pkg::RST_CADENCE_SECONDS;
      ignored_requests_r <= trsr_pkg::RST_IGNORED_REQUESTS;
      trim_step_r        <= trsr_pkg::RST_TRIM_STEP;
      respond_gain_r     <= trsr_pkg::RST_RESPOND_GAIN;
      respond_limit_r    <= trsr_pkg::RST_RESPOND_LIMIT;
    end else if (cfg_we) begin
      unique case (trsr_pkg::cfg_reg_t'(cfg_addr))
        trsr_pkg::REG_INITIAL_SETPOINT: initial_setpoint_r <= cfg_wdata;
        trsr_pkg::REG_SETPOINT_FLOOR:   setpoint_floor_r   <= cfg_wdata;
        trsr_pkg::REG_SETPOINT_CEILING: setpoint_ceiling_r <= cfg_wdata;
        trsr_pkg::REG_CADENCE_SECONDS:  cadence_seconds_r  <= cfg_wdata;
        trsr_pkg::REG_IGNORED_REQUESTS: ignored_requests_r <= cfg_wdata[trsr_pkg::REQ_W-1:0];
        trsr_pkg::REG_TRIM_STEP:        trim_step_r        <= cfg_wdata;
        trsr_pkg::REG_RESPOND_GAIN:     respond_gain_r     <= cfg_wdata;
        trsr_pkg::REG_RESPOND_LIMIT:    respond_limit_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Loop state: advance only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r      <= '0;
      startup_timer_r <= '0;
      cadence_timer_r <= '0;
      fan_was_on_r    <= 1'b0;
    end else if (accept) begin
      setpoint_r      <= setpoint_nxt;
      startup_timer_r <= startup_timer_nxt;
      cadence_timer_r <= cadence_timer_nxt;
      fan_was_on_r    <= fan_was_on_nxt;
    end
  end

  // Result slot: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_setpoint_r <= setpoint_nxt;
      out_action_r   <= action_nxt;
    end
  end

endmodule
